/* rtl/dlr_pkg.sv */
// dlr_pkg: shared widths, register indexes, pipeline word types and the
// arithmetic helpers of the daylight ramp brightness block
// no dependencies
package dlr_pkg;

    localparam int HOUR_W     = 5;
    localparam int MIN_W      = 6;
    localparam int TIME_W     = 12;
    localparam int LEN_W      = 11;
    localparam int LEVEL_W    = 8;
    localparam int QUO_W      = LEVEL_W;
    localparam int PROD_W     = LEVEL_W + LEN_W;
    localparam int IDX_W      = 3;
    localparam int CFG_W      = 11;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int QSTEP_W    = $clog2(QUO_W);

    localparam logic [TIME_W-1:0] MINUTES_PER_HOUR = TIME_W'(60);

    typedef enum logic [IDX_W-1:0] {
        REG_START_HOUR   = 3'd0,
        REG_START_MINUTE = 3'd1,
        REG_END_HOUR     = 3'd2,
        REG_END_MINUTE   = 3'd3,
        REG_RISE_MINUTES = 3'd4,
        REG_FALL_MINUTES = 3'd5,
        REG_PEAK_LEVEL   = 3'd6
    } reg_index_t;

    // classified time sample, after the window test
    typedef struct packed {
        logic               zero;
        logic               sat_up;
        logic               sat_dn;
        logic [LEVEL_W-1:0] peak;
        logic [LEN_W-1:0]   elapsed_up;
        logic [LEN_W-1:0]   elapsed_dn;
        logic [LEN_W-1:0]   len_up;
        logic [LEN_W-1:0]   len_dn;
    } dlr_class_t;

    // word carried through the queue and the divider stages
    typedef struct packed {
        logic               zero;
        logic               sat_up;
        logic               sat_dn;
        logic [LEVEL_W-1:0] peak;
        logic [PROD_W-1:0]  rem_up;
        logic [PROD_W-1:0]  rem_dn;
        logic [LEN_W-1:0]   div_up;
        logic [LEN_W-1:0]   div_dn;
        logic [QUO_W-1:0]   quo_up;
        logic [QUO_W-1:0]   quo_dn;
    } dlr_work_t;

    function automatic logic [TIME_W-1:0] minute_count(
        input logic [HOUR_W-1:0] hour,
        input logic [MIN_W-1:0]  minute
    );
        return TIME_W'(TIME_W'(hour) * MINUTES_PER_HOUR) + TIME_W'(minute);
    endfunction

    // one restoring division step for both ramps, quotient bit b
    function automatic dlr_work_t div_step(
        input dlr_work_t          w,
        input logic [QSTEP_W-1:0] b
    );
        dlr_work_t         r;
        logic [PROD_W-1:0] sh_up;
        logic [PROD_W-1:0] sh_dn;
        r     = w;
        sh_up = PROD_W'(w.div_up) << b;
        sh_dn = PROD_W'(w.div_dn) << b;
        if (w.rem_up >= sh_up) begin
            r.rem_up    = w.rem_up - sh_up;
            r.quo_up[b] = 1'b1;
        end
        if (w.rem_dn >= sh_dn) begin
            r.rem_dn    = w.rem_dn - sh_dn;
            r.quo_dn[b] = 1'b1;
        end
        return r;
    endfunction

endpackage

/* rtl/dlr_front.sv */
// dlr_front: schedule registers, window test and ramp numerators
// two register stages; uses dlr_pkg
module dlr_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic [dlr_pkg::IDX_W-1:0]   cfg_index,
    input  logic [dlr_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [dlr_pkg::HOUR_W-1:0]  s_hour_of_day,
    input  logic [dlr_pkg::MIN_W-1:0]   s_minute_of_hour,
    input  logic                        s_clock_valid,
    output logic                        out_valid,
    input  logic                        out_ready,
    output dlr_pkg::dlr_work_t          out_data
);
    import dlr_pkg::*;

    logic [HOUR_W-1:0]  start_hour_reg;
    logic [MIN_W-1:0]   start_minute_reg;
    logic [HOUR_W-1:0]  end_hour_reg;
    logic [MIN_W-1:0]   end_minute_reg;
    logic [LEN_W-1:0]   rise_minutes_reg;
    logic [LEN_W-1:0]   fall_minutes_reg;
    logic [LEVEL_W-1:0] peak_level_reg;

    dlr_class_t cls_reg, cls_next;
    logic       cls_valid_reg;
    dlr_work_t  work_reg, work_next;
    logic       work_valid_reg;
    logic       adv;

    logic [TIME_W-1:0] now_t, open_t, close_t, d_up, d_dn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_hour_reg   <= '0;
            start_minute_reg <= '0;
            end_hour_reg     <= '0;
            end_minute_reg   <= '0;
            rise_minutes_reg <= '0;
            fall_minutes_reg <= '0;
            peak_level_reg   <= '0;
        end else if (cfg_valid) begin
            case (reg_index_t'(cfg_index))
                REG_START_HOUR:   start_hour_reg   <= cfg_data[HOUR_W-1:0];
                REG_START_MINUTE: start_minute_reg <= cfg_data[MIN_W-1:0];
                REG_END_HOUR:     end_hour_reg     <= cfg_data[HOUR_W-1:0];
                REG_END_MINUTE:   end_minute_reg   <= cfg_data[MIN_W-1:0];
                REG_RISE_MINUTES: rise_minutes_reg <= cfg_data[LEN_W-1:0];
                REG_FALL_MINUTES: fall_minutes_reg <= cfg_data[LEN_W-1:0];
                REG_PEAK_LEVEL:   peak_level_reg   <= cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv     = !work_valid_reg || out_ready;
    assign s_ready = adv;

    always_comb begin
        now_t   = minute_count(s_hour_of_day, s_minute_of_hour);
        open_t  = minute_count(start_hour_reg, start_minute_reg);
        close_t = minute_count(end_hour_reg, end_minute_reg);
        d_up    = now_t - open_t;
        d_dn    = close_t - now_t;

        cls_next.zero       = !(s_clock_valid && (now_t > open_t) && (now_t < close_t));
        cls_next.sat_up     = d_up >= TIME_W'(rise_minutes_reg);
        cls_next.sat_dn     = d_dn >= TIME_W'(fall_minutes_reg);
        cls_next.peak       = peak_level_reg;
        // below the ramp length the distance fits the length width
        cls_next.elapsed_up = d_up[LEN_W-1:0];
        cls_next.elapsed_dn = d_dn[LEN_W-1:0];
        cls_next.len_up     = rise_minutes_reg;
        cls_next.len_dn     = fall_minutes_reg;
    end

    always_comb begin
        work_next.zero   = cls_reg.zero;
        work_next.sat_up = cls_reg.sat_up;
        work_next.sat_dn = cls_reg.sat_dn;
        work_next.peak   = cls_reg.peak;
        work_next.rem_up = cls_reg.sat_up ? '0
                         : PROD_W'(cls_reg.peak) * PROD_W'(cls_reg.elapsed_up);
        work_next.rem_dn = cls_reg.sat_dn ? '0
                         : PROD_W'(cls_reg.peak) * PROD_W'(cls_reg.elapsed_dn);
        work_next.div_up = cls_reg.len_up;
        work_next.div_dn = cls_reg.len_dn;
        work_next.quo_up = '0;
        work_next.quo_dn = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cls_valid_reg  <= 1'b0;
            work_valid_reg <= 1'b0;
        end else if (adv) begin
            cls_valid_reg  <= s_valid;
            work_valid_reg <= cls_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cls_reg  <= cls_next;
            work_reg <= work_next;
        end
    end

    assign out_valid = work_valid_reg;
    assign out_data  = work_reg;

endmodule

/* rtl/dlr_fifo.sv */
// dlr_fifo: short word queue between the classifier and the divider
// uses dlr_pkg for the word type and depth
module dlr_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  dlr_pkg::dlr_work_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output dlr_pkg::dlr_work_t pop_data
);
    import dlr_pkg::*;

    dlr_work_t          mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               push, pop;

    assign push_ready = count_reg != (FIFO_AW+1)'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? FIFO_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? FIFO_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/dlr_back.sv */
// dlr_back: pipelined restoring divider for both ramps, one quotient bit
// per stage, then the min and the output register; uses dlr_pkg
module dlr_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  dlr_pkg::dlr_work_t          in_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [dlr_pkg::LEVEL_W-1:0] m_level
);
    import dlr_pkg::*;

    dlr_work_t          stg_reg       [QUO_W];
    logic               stg_valid_reg [QUO_W];
    logic               m_valid_reg;
    logic [LEVEL_W-1:0] m_level_reg, m_level_next;
    logic [LEVEL_W-1:0] up_val, dn_val;
    dlr_work_t          last;
    logic               adv;

    // whole pipeline moves together unless the result is held
    assign adv      = !m_valid_reg || m_ready;
    assign in_ready = adv;

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        if (k == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (adv) begin
                    stg_reg[k] <= div_step(in_data, QSTEP_W'(QUO_W-1-k));
                end
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    stg_valid_reg[k] <= 1'b0;
                end else if (adv) begin
                    stg_valid_reg[k] <= in_valid;
                end
            end
        end else begin : g_next
            always_ff @(posedge aclk) begin
                if (adv) begin
                    stg_reg[k] <= div_step(stg_reg[k-1], QSTEP_W'(QUO_W-1-k));
                end
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    stg_valid_reg[k] <= 1'b0;
                end else if (adv) begin
                    stg_valid_reg[k] <= stg_valid_reg[k-1];
                end
            end
        end
    end

    always_comb begin
        last         = stg_reg[QUO_W-1];
        up_val       = last.sat_up ? last.peak : last.quo_up;
        dn_val       = last.sat_dn ? last.peak : last.quo_dn;
        m_level_next = '0;
        if (!last.zero) begin
            m_level_next = (up_val < dn_val) ? up_val : dn_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= stg_valid_reg[QUO_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_level_reg <= m_level_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_level = m_level_reg;

endmodule

/* rtl/daylight_ramp_brightness_top.sv */
// daylight_ramp_brightness_top: brightness of one led strip from the time
// of day; connects dlr_front, dlr_fifo and dlr_back, uses dlr_pkg
//
// usage:
// - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   schedule: 0 start hour, 1 start minute, 2 end hour, 3 end minute,
//   4 rise minutes, 5 fall minutes, 6 peak level; other indexes are
//   dropped. cfg_ready is always high; write only while the block is idle
// - s channel takes one time sample per word (hour, minute, clock valid)
// - m channel returns one level word per sample, in order
// - path: a word accepted on s passes 2 classifier stages, 1 queue slot,
//   8 divider stages and the output register before it shows on m_valid
// - throughput: one word per cycle while not stalled; the divider resolves one quotient bit
//   per stage for both ramps in parallel
// - when m_ready is low with a result waiting, the divider pipeline holds, the 4-word queue
//   fills, and then s_ready drops
// - reset (aresetn low, synchronous) empties all stages and the queue and
//   clears every schedule register to 0
module daylight_ramp_brightness_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dlr_pkg::IDX_W-1:0]   cfg_index,
    input  logic [dlr_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [dlr_pkg::HOUR_W-1:0]  s_hour_of_day,
    input  logic [dlr_pkg::MIN_W-1:0]   s_minute_of_hour,
    input  logic                        s_clock_valid,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [dlr_pkg::LEVEL_W-1:0] m_level
);
    import dlr_pkg::*;

    logic      fr_valid, fr_ready;
    dlr_work_t fr_data;
    logic      q_valid, q_ready;
    dlr_work_t q_data;

    assign cfg_ready = 1'b1;

    dlr_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_hour_of_day    (s_hour_of_day),
        .s_minute_of_hour (s_minute_of_hour),
        .s_clock_valid    (s_clock_valid),
        .out_valid        (fr_valid),
        .out_ready        (fr_ready),
        .out_data         (fr_data)
    );

    dlr_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_data  (fr_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    dlr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_data  (q_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_level  (m_level)
    );

endmodule

/* rtl/dlr_checker.sv */
// dlr_checker: port-level assertions for daylight_ramp_brightness_top
// bound to the top level below; uses dlr_pkg for port widths
module dlr_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        cfg_ready,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [dlr_pkg::LEVEL_W-1:0] m_level
);

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high right after reset");

    // with all stages empty the input side must be open
    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("s_ready low right after reset");

    // schedule writes are never back-pressured
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("cfg_ready dropped");

    // a held result word keeps its level
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_level))
        else $error("result word changed while stalled");

endmodule

bind daylight_ramp_brightness_top dlr_checker u_dlr_checker (.*);
